FILE: hdl/v2m_pkg.sv
// shared types, constants and helper functions of the 2d vector math unit
`timescale 1ns / 1ps
package v2m_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int FRAC_BITS_DEF = 16;

	// cordic datapath width, split point of the gain multiply, magnitude width
	localparam int CW = 36;
	localparam int CW_LO = 18;
	localparam int MW = 34;
	localparam int SAT_W = 72;

	// reciprocal of the cordic gain in q0.30
	localparam logic [29:0] INV_GAIN = 30'd652032874;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	typedef enum logic [2:0] {
		OP_ROTATE,
		OP_POLAR,
		OP_MAG_ANGLE,
		OP_NORMALIZE,
		OP_DOT,
		OP_DISTANCE,
		OP_LERP,
		OP_ANGLE_BETWEEN
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] angle;
		logic signed [31:0] weight;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic signed [31:0] scalar;
		logic signed [31:0] result_angle;
		logic               fault;
	} res_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
		logic                 vec;
	} cordic_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] w;
		logic               zero_a;
		logic               zero_b;
		logic               zero_d;
	} side_t;

	typedef struct packed {
		op_t                  op;
		logic signed [CW-1:0] gx;
		logic signed [CW-1:0] gy;
		logic [31:0]          za;
		logic [31:0]          zb;
		logic signed [31:0]   dot;
		logic signed [31:0]   lerp_x;
		logic signed [31:0]   lerp_y;
		logic signed [31:0]   ax;
		logic signed [31:0]   ay;
		logic                 zero_a;
		logic                 zero_b;
		logic                 zero_d;
	} post_t;

	// atan(2^-i) as a binary angle
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			5'd31: a = 32'd0;
		endcase
		return a;
	endfunction

	// clip to the int32 range
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-32:0] hi;
		hi = v[SAT_W-1:31];
		if ((&hi) || !(|hi))
			return v[31:0];
		return v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

endpackage

FILE: hdl/vector2d_math_unit_top.sv
// top level of the 2d vector math unit
// Fixed-point 2D vector unit: each request carries an operation and two vectors,
// an angle and a weight, and yields exactly one result. The work is a single
// pipeline that takes a new request in every cycle unless stalled: an input
// register, one stage per cordic iteration (CORDIC_STEPS stages, two lanes side
// by side), two multiply stages for gain removal, dot product and interpolation,
// one stage per quotient bit of the normalize division (32 + FRAC_BITS stages)
// and the output register. Every operation passes through all of these stages.
// All operations share the same path, so results leave in request order. When
// res_ready is low with a result held, the whole pipeline stalls together; no
// request is lost or repeated. Angles are binary angles (a full turn is 2^32),
// vectors are Q(32-FRAC_BITS).FRAC_BITS and every vector and scalar result
// saturates to the int32 range.
`timescale 1ns / 1ps
module vector2d_math_unit_top #(
	parameter int CORDIC_STEPS = v2m_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = v2m_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  v2m_pkg::req_t   req_data,
	output logic            res_valid,
	input  logic            res_ready,
	output v2m_pkg::res_t   res_data
);

	localparam int DB = 32 + FRAC_BITS;
	localparam int CW = v2m_pkg::CW;
	localparam int MW = v2m_pkg::MW;
	localparam int SW = v2m_pkg::SAT_W;
	localparam logic signed [31:0] ONE = 32'(1 << FRAC_BITS);

	// result waiting for the divider, plus what the divider output needs
	typedef struct packed {
		v2m_pkg::res_t res;
		logic          norm;
		logic          neg_x;
		logic          neg_y;
	} pre_t;

	// one stall signal for the whole pipeline
	logic en;
	logic res_valid_q;
	v2m_pkg::res_t res_q;

	// end of the divider and the result it feeds
	pre_t          pre_d;
	logic          v_d;
	v2m_pkg::res_t res_n;

	assign en        = !res_valid_q || res_ready;
	assign req_ready = en;

	// input register
	v2m_pkg::req_t req_s1;
	logic          v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= req_valid;
			res_valid_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1 <= req_data;
			res_q  <= res_n;
		end
	end

	// cordic pre-rotation: vectoring folds the left half plane over,
	// rotation brings the target angle within a quarter turn
	function automatic v2m_pkg::cordic_t cordic_pre(input v2m_pkg::cordic_t c);
		v2m_pkg::cordic_t r;
		r = c;
		if (c.vec) begin
			if (c.x[CW-1]) begin
				r.x = -c.x;
				r.y = -c.y;
				r.z = v2m_pkg::HALF_TURN;
			end
		end else if (((c.z + v2m_pkg::QUARTER_TURN) & v2m_pkg::HALF_TURN) != '0) begin
			r.x = -c.x;
			r.y = -c.y;
			r.z = c.z + v2m_pkg::HALF_TURN;
		end
		return r;
	endfunction

	v2m_pkg::cordic_t raw_a, raw_b;
	v2m_pkg::cordic_t lane_a_in, lane_b_in;
	v2m_pkg::side_t   side_in;

	always_comb begin
		// lane a: the first vector, or the difference for distance
		raw_a.x   = CW'(req_s1.first_x);
		raw_a.y   = CW'(req_s1.first_y);
		raw_a.z   = '0;
		raw_a.vec = 1'b1;
		unique case (req_s1.op)
			v2m_pkg::OP_ROTATE: begin
				raw_a.z   = req_s1.angle;
				raw_a.vec = 1'b0;
			end
			v2m_pkg::OP_POLAR: begin
				raw_a.y   = '0;
				raw_a.z   = req_s1.angle;
				raw_a.vec = 1'b0;
			end
			v2m_pkg::OP_DISTANCE: begin
				raw_a.x = CW'(req_s1.second_x) - CW'(req_s1.first_x);
				raw_a.y = CW'(req_s1.second_y) - CW'(req_s1.first_y);
			end
			default: begin
			end
		endcase

		// lane b: angle of the second vector, used by angle between
		raw_b.x   = CW'(req_s1.second_x);
		raw_b.y   = CW'(req_s1.second_y);
		raw_b.z   = '0;
		raw_b.vec = 1'b1;

		lane_a_in = cordic_pre(raw_a);
		lane_b_in = cordic_pre(raw_b);

		side_in.op = req_s1.op;
		side_in.ax = req_s1.first_x;
		side_in.ay = req_s1.first_y;
		side_in.bx = req_s1.second_x;
		side_in.by = req_s1.second_y;
		// interpolation weight clamped to 0..1
		if ($signed(req_s1.weight) < 32'sd0)
			side_in.w = '0;
		else if ($signed(req_s1.weight) > ONE)
			side_in.w = ONE;
		else
			side_in.w = req_s1.weight;
		side_in.zero_a = (req_s1.first_x == '0) && (req_s1.first_y == '0);
		side_in.zero_b = (req_s1.second_x == '0) && (req_s1.second_y == '0);
		side_in.zero_d = (req_s1.first_x == req_s1.second_x) &&
			(req_s1.first_y == req_s1.second_y);
	end

	// cordic chain, two lanes
	v2m_pkg::cordic_t lane_a [CORDIC_STEPS+1];
	v2m_pkg::cordic_t lane_b [CORDIC_STEPS+1];

	assign lane_a[0] = lane_a_in;
	assign lane_b[0] = lane_b_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		v2m_cordic_stage #(.SHIFT(i)) u_stage_a (
			.clk     (clk),
			.en      (en),
			.stage   (lane_a[i]),
			.stage_s (lane_a[i+1])
		);
		v2m_cordic_stage #(.SHIFT(i)) u_stage_b (
			.clk     (clk),
			.en      (en),
			.stage   (lane_b[i]),
			.stage_s (lane_b[i+1])
		);
	end

	// operands and flags travel beside the cordic chain
	v2m_pkg::side_t side_c;
	logic           v_c;

	v2m_delay #(
		.WIDTH ($bits(v2m_pkg::side_t)),
		.DEPTH (CORDIC_STEPS)
	) u_side_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (v_s1),
		.data    (side_in),
		.valid_s (v_c),
		.data_s  (side_c)
	);

	// gain removal, dot product, interpolation
	v2m_pkg::post_t post_m;
	logic           v_m;

	v2m_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (v_c),
		.lane     (lane_a[CORDIC_STEPS]),
		.zb       (lane_b[CORDIC_STEPS].z),
		.side     (side_c),
		.valid_s2 (v_m),
		.post_s2  (post_m)
	);

	// results for every operation but normalize are settled here
	pre_t        pre;
	logic [31:0] abs_x, abs_y;
	logic [31:0] d_ang;

	always_comb begin
		pre   = '0;
		abs_x = post_m.ax[31] ? (~post_m.ax + 32'd1) : post_m.ax;
		abs_y = post_m.ay[31] ? (~post_m.ay + 32'd1) : post_m.ay;
		d_ang = post_m.zb - post_m.za;
		unique case (post_m.op)
			v2m_pkg::OP_ROTATE, v2m_pkg::OP_POLAR: begin
				pre.res.result_x = v2m_pkg::sat32(SW'(post_m.gx));
				pre.res.result_y = v2m_pkg::sat32(SW'(post_m.gy));
			end
			v2m_pkg::OP_MAG_ANGLE: begin
				if (!post_m.zero_a) begin
					pre.res.scalar       = v2m_pkg::sat32(SW'(post_m.gx));
					pre.res.result_angle = post_m.za;
				end
			end
			v2m_pkg::OP_NORMALIZE: begin
				pre.norm      = 1'b1;
				pre.neg_x     = post_m.ax[31];
				pre.neg_y     = post_m.ay[31];
				// magnitude of zero, from a zero vector or from rounding
				pre.res.fault = (post_m.gx == '0);
			end
			v2m_pkg::OP_DOT: begin
				pre.res.scalar = post_m.dot;
			end
			v2m_pkg::OP_DISTANCE: begin
				if (!post_m.zero_d)
					pre.res.scalar = v2m_pkg::sat32(SW'(post_m.gx));
			end
			v2m_pkg::OP_LERP: begin
				pre.res.result_x = post_m.lerp_x;
				pre.res.result_y = post_m.lerp_y;
			end
			v2m_pkg::OP_ANGLE_BETWEEN: begin
				if (post_m.zero_a || post_m.zero_b)
					pre.res.fault = 1'b1;
				else
					pre.res.result_angle = d_ang[31] ? (~d_ang + 32'd1) : d_ang;
			end
		endcase
	end

	// normalize division, one quotient bit per stage
	logic [MW-1:0]            dv  [DB+1];
	logic [1:0][MW-1:0]       rm  [DB+1];
	logic [1:0][DB-1:0]       nqa [DB+1];

	assign dv[0]     = post_m.gx[MW-1:0];
	assign rm[0]     = '0;
	assign nqa[0][0] = {abs_x, {FRAC_BITS{1'b0}}};
	assign nqa[0][1] = {abs_y, {FRAC_BITS{1'b0}}};

	for (genvar j = 0; j < DB; j++) begin : g_div
		v2m_div_stage #(.DB(DB)) u_div_stage (
			.clk       (clk),
			.en        (en),
			.divisor   (dv[j]),
			.rem       (rm[j]),
			.nq        (nqa[j]),
			.divisor_s (dv[j+1]),
			.rem_s     (rm[j+1]),
			.nq_s      (nqa[j+1])
		);
	end

	v2m_delay #(
		.WIDTH ($bits(pre_t)),
		.DEPTH (DB)
	) u_pre_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (v_m),
		.data    (pre),
		.valid_s (v_d),
		.data_s  (pre_d)
	);

	// signed, saturated quotient; division truncates toward zero
	function automatic logic signed [31:0] norm_out(input logic [DB-1:0] q, input logic neg);
		logic over_pos;
		logic over_neg;
		over_pos = |q[DB-1:31];
		over_neg = (|q[DB-1:32]) || (q[31] && (|q[30:0]));
		if (neg)
			return over_neg ? 32'sh8000_0000 : $signed(~q[31:0] + 32'd1);
		return over_pos ? 32'sh7fff_ffff : $signed(q[31:0]);
	endfunction

	always_comb begin
		res_n = pre_d.res;
		if (pre_d.norm && !pre_d.res.fault) begin
			res_n.result_x = norm_out(nqa[DB][0], pre_d.neg_x);
			res_n.result_y = norm_out(nqa[DB][1], pre_d.neg_y);
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

FILE: hdl/v2m_delay.sv
// register line that carries side data and valid bits alongside a pipeline
`timescale 1ns / 1ps
module v2m_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid,
	input  logic [WIDTH-1:0] data,
	output logic             valid_s,
	output logic [WIDTH-1:0] data_s
);

	logic [DEPTH-1:0]            v_s;
	logic [DEPTH-1:0][WIDTH-1:0] d_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s[0] <= valid;
			for (int k = 1; k < DEPTH; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= data;
			for (int k = 1; k < DEPTH; k++)
				d_s[k] <= d_s[k-1];
		end
	end

	assign valid_s = v_s[DEPTH-1];
	assign data_s  = d_s[DEPTH-1];

endmodule

FILE: hdl/v2m_cordic_stage.sv
// one registered cordic iteration, rotation or vectoring mode
`timescale 1ns / 1ps
module v2m_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              en,
	input  v2m_pkg::cordic_t  stage,
	output v2m_pkg::cordic_t  stage_s
);

	logic signed [v2m_pkg::CW-1:0] xs;
	logic signed [v2m_pkg::CW-1:0] ys;
	logic [31:0]                   a;
	logic                          neg;
	v2m_pkg::cordic_t              nxt;

	always_comb begin
		xs  = $signed(stage.x) >>> SHIFT;
		ys  = $signed(stage.y) >>> SHIFT;
		a   = v2m_pkg::atan_entry(5'(SHIFT));
		// vectoring drives y to zero, rotation drives z to zero
		neg = stage.vec ? ~stage.y[v2m_pkg::CW-1] : stage.z[31];
		nxt.vec = stage.vec;
		if (neg) begin
			nxt.x = stage.x + ys;
			nxt.y = stage.y - xs;
			nxt.z = stage.z + a;
		end else begin
			nxt.x = stage.x - ys;
			nxt.y = stage.y + xs;
			nxt.z = stage.z - a;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			stage_s <= nxt;
	end

endmodule

FILE: hdl/v2m_mul.sv
// two multiply stages: cordic gain removal, dot product and interpolation
`timescale 1ns / 1ps
module v2m_mul #(
	parameter int FRAC_BITS = v2m_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid,
	input  v2m_pkg::cordic_t lane,
	input  logic [31:0]      zb,
	input  v2m_pkg::side_t   side,
	output logic             valid_s2,
	output v2m_pkg::post_t   post_s2
);

	localparam int XH   = v2m_pkg::CW - v2m_pkg::CW_LO;
	localparam int PW   = v2m_pkg::CW_LO + 30;
	localparam int HW   = XH + 31;
	localparam int GW   = HW + v2m_pkg::CW_LO + 1;
	localparam int LW   = 35 + FRAC_BITS;
	localparam int LSW  = LW + 1;
	localparam int DW   = 66;
	localparam int SW   = v2m_pkg::SAT_W;
	localparam int HALF = 1 << (FRAC_BITS - 1);
	localparam logic [GW-1:0] RND_G = {{(GW-30){1'b0}}, 1'b1, 29'd0};

	// stage 1
	logic signed [HW-1:0]    ph_x_s1, ph_y_s1;
	logic [PW-1:0]           pl_x_s1, pl_y_s1;
	logic signed [63:0]      p1_s1, p2_s1;
	logic signed [LW-1:0]    lp_x_s1, lp_y_s1;
	logic [31:0]             za_s1, zb_s1;
	v2m_pkg::side_t          side_s1;
	logic                    v_s1;

	logic signed [HW-1:0]    ph_x, ph_y;
	logic [PW-1:0]           pl_x, pl_y;
	logic signed [63:0]      p1, p2;
	logic signed [32:0]      dxl, dyl;
	logic signed [FRAC_BITS+1:0] wn;
	logic signed [LW-1:0]    lp_x, lp_y;

	always_comb begin
		ph_x = $signed(lane.x[v2m_pkg::CW-1:v2m_pkg::CW_LO]) * $signed({1'b0, v2m_pkg::INV_GAIN});
		ph_y = $signed(lane.y[v2m_pkg::CW-1:v2m_pkg::CW_LO]) * $signed({1'b0, v2m_pkg::INV_GAIN});
		pl_x = lane.x[v2m_pkg::CW_LO-1:0] * v2m_pkg::INV_GAIN;
		pl_y = lane.y[v2m_pkg::CW_LO-1:0] * v2m_pkg::INV_GAIN;
		p1   = side.ax * side.bx;
		p2   = side.ay * side.by;
		dxl  = $signed({side.bx[31], side.bx}) - $signed({side.ax[31], side.ax});
		dyl  = $signed({side.by[31], side.by}) - $signed({side.ay[31], side.ay});
		wn   = $signed(side.w[FRAC_BITS+1:0]);
		lp_x = dxl * wn;
		lp_y = dyl * wn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			v_s1     <= valid;
			valid_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_x_s1 <= ph_x;
			ph_y_s1 <= ph_y;
			pl_x_s1 <= pl_x;
			pl_y_s1 <= pl_y;
			p1_s1   <= p1;
			p2_s1   <= p2;
			lp_x_s1 <= lp_x;
			lp_y_s1 <= lp_y;
			za_s1   <= lane.z;
			zb_s1   <= zb;
			side_s1 <= side;
		end
	end

	// stage 2
	logic signed [GW-1:0]  gsx, gsy;
	logic signed [DW-1:0]  ds, dq;
	logic signed [LSW-1:0] lsx, lsy;
	logic signed [SW-1:0]  lrx, lry;
	v2m_pkg::post_t        post;

	always_comb begin
		gsx = (GW'(ph_x_s1) <<< v2m_pkg::CW_LO) + GW'(pl_x_s1) + RND_G;
		gsy = (GW'(ph_y_s1) <<< v2m_pkg::CW_LO) + GW'(pl_y_s1) + RND_G;
		ds  = DW'(p1_s1) + DW'(p2_s1) + DW'(HALF);
		dq  = ds >>> FRAC_BITS;
		lsx = LSW'(lp_x_s1) + LSW'(HALF);
		lsy = LSW'(lp_y_s1) + LSW'(HALF);
		lrx = SW'(lsx >>> FRAC_BITS) + SW'(side_s1.ax);
		lry = SW'(lsy >>> FRAC_BITS) + SW'(side_s1.ay);

		post.op     = side_s1.op;
		post.gx     = gsx[v2m_pkg::CW+29:30];
		post.gy     = gsy[v2m_pkg::CW+29:30];
		post.za     = za_s1;
		post.zb     = zb_s1;
		post.dot    = v2m_pkg::sat32(SW'(dq));
		post.lerp_x = v2m_pkg::sat32(lrx);
		post.lerp_y = v2m_pkg::sat32(lry);
		post.ax     = side_s1.ax;
		post.ay     = side_s1.ay;
		post.zero_a = side_s1.zero_a;
		post.zero_b = side_s1.zero_b;
		post.zero_d = side_s1.zero_d;
	end

	always_ff @(posedge clk) begin
		if (en)
			post_s2 <= post;
	end

endmodule

FILE: hdl/v2m_div_stage.sv
// one registered restoring division step for the x and y quotients
`timescale 1ns / 1ps
module v2m_div_stage #(
	parameter int DB = 48
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [v2m_pkg::MW-1:0]            divisor,
	input  logic [1:0][v2m_pkg::MW-1:0]       rem,
	input  logic [1:0][DB-1:0]                nq,
	output logic [v2m_pkg::MW-1:0]            divisor_s,
	output logic [1:0][v2m_pkg::MW-1:0]       rem_s,
	output logic [1:0][DB-1:0]                nq_s
);

	logic [1:0][v2m_pkg::MW:0]   t;
	logic [1:0][v2m_pkg::MW:0]   diff;
	logic [1:0]                  ge;
	logic [1:0][v2m_pkg::MW-1:0] rem_n;
	logic [1:0][DB-1:0]          nq_n;

	// dividend bits leave at the top of nq while quotient bits enter below
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			t[k]     = {rem[k], nq[k][DB-1]};
			diff[k]  = t[k] - {1'b0, divisor};
			ge[k]    = t[k] >= {1'b0, divisor};
			rem_n[k] = ge[k] ? diff[k][v2m_pkg::MW-1:0] : t[k][v2m_pkg::MW-1:0];
			nq_n[k]  = {nq[k][DB-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			divisor_s <= divisor;
			rem_s     <= rem_n;
			nq_s      <= nq_n;
		end
	end

endmodule

FILE: tb/vector2d_math_unit_top_test.sv
// self-checking testbench of the 2d vector math unit with its own bit-exact predictor
`timescale 1ns / 1ps
module vector2d_math_unit_top_test;

	// expected results of the vector unit, kept in request order
	class vector_scoreboard;
		localparam int STEPS = v2m_pkg::CORDIC_STEPS_DEF;
		localparam int FRAC = v2m_pkg::FRAC_BITS_DEF;
		localparam longint GAIN_INV = 652032874;
		localparam logic [31:0] HALF = 32'h8000_0000;
		localparam logic [31:0] QUARTER = 32'h4000_0000;

		logic [31:0] arctan [32];
		v2m_pkg::res_t pending [$];
		int errors;

		function new();
			arctan = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
				32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
				32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
				32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326,
				32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
			errors = 0;
		endfunction

		function logic [31:0] clip(longint v);
			if (v > 64'sd2147483647) return 32'h7fff_ffff;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return v[31:0];
		endfunction

		// length and direction of (x,y)
		function void to_polar(longint x, longint y, output longint mag,
				output logic [31:0] dir);
			logic [31:0] z;
			longint dx, dy;
			longint unsigned ux;
			z = 0;
			if (x < 0) begin
				x = -x; y = -y; z = HALF;
			end
			for (int i = 0; i < STEPS && i < 32; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += arctan[i];
				end else begin
					x -= dx; y += dy; z -= arctan[i];
				end
			end
			ux = x;
			mag = (ux * 64'd652032874 + 64'd536870912) >> 30;
			dir = z;
		endfunction

		// (x,y) turned by z with the gain taken out
		function void turn(longint x, longint y, logic [31:0] z, output longint ox,
				output longint oy);
			longint dx, dy;
			if (((z + QUARTER) & HALF) != 0) begin
				x = -x; y = -y; z += HALF;
			end
			for (int i = 0; i < STEPS && i < 32; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (!z[31]) begin
					x -= dx; y += dy; z -= arctan[i];
				end else begin
					x += dx; y -= dy; z += arctan[i];
				end
			end
			ox = (x * GAIN_INV + (64'sd1 <<< 29)) >>> 30;
			oy = (y * GAIN_INV + (64'sd1 <<< 29)) >>> 30;
		endfunction

		function v2m_pkg::res_t compute(v2m_pkg::req_t r);
			v2m_pkg::res_t e;
			longint ax, ay, bx, by, w, rx, ry, mag, p1, p2, lows, one;
			logic [31:0] a1, a2, d;
			e = '0;
			ax = r.first_x; ay = r.first_y; bx = r.second_x; by = r.second_y;
			w = r.weight;
			one = 64'sd1 <<< FRAC;
			mag = 0;
			case (r.op)
				v2m_pkg::OP_ROTATE: begin
					turn(ax, ay, r.angle, rx, ry);
					e.result_x = clip(rx); e.result_y = clip(ry);
				end
				v2m_pkg::OP_POLAR: begin
					turn(ax, 0, r.angle, rx, ry);
					e.result_x = clip(rx); e.result_y = clip(ry);
				end
				v2m_pkg::OP_MAG_ANGLE: if (ax != 0 || ay != 0) begin
					to_polar(ax, ay, mag, a1);
					e.scalar = clip(mag); e.result_angle = a1;
				end
				v2m_pkg::OP_NORMALIZE: begin
					if (ax != 0 || ay != 0) to_polar(ax, ay, mag, a1);
					if (mag == 0) e.fault = 1'b1;
					else begin
						e.result_x = clip((ax <<< FRAC) / mag);
						e.result_y = clip((ay <<< FRAC) / mag);
					end
				end
				v2m_pkg::OP_DOT: begin
					p1 = ax * bx;
					p2 = ay * by;
					lows = (p1 & (one - 1)) + (p2 & (one - 1)) + (one >>> 1);
					e.scalar = clip((p1 >>> FRAC) + (p2 >>> FRAC) + (lows >>> FRAC));
				end
				v2m_pkg::OP_DISTANCE: if (bx != ax || by != ay) begin
					to_polar(bx - ax, by - ay, mag, a1);
					e.scalar = clip(mag);
				end
				v2m_pkg::OP_LERP: begin
					if (w < 0) w = 0;
					if (w > one) w = one;
					e.result_x = clip(ax + (((bx - ax) * w + (one >>> 1)) >>> FRAC));
					e.result_y = clip(ay + (((by - ay) * w + (one >>> 1)) >>> FRAC));
				end
				default: begin
					if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) e.fault = 1'b1;
					else begin
						to_polar(ax, ay, mag, a1);
						to_polar(bx, by, mag, a2);
						d = a2 - a1;
						if (d[31]) d = -d;
						e.result_angle = d;
					end
				end
			endcase
			return e;
		endfunction

		function void note_request(v2m_pkg::req_t r);
			pending.push_back(compute(r));
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_result(v2m_pkg::res_t got);
			v2m_pkg::res_t want;
			if (pending.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			want = pending.pop_front();
			field("result_x", got.result_x, want.result_x);
			field("result_y", got.result_y, want.result_y);
			field("scalar", got.scalar, want.scalar);
			field("result_angle", got.result_angle, want.result_angle);
			field("fault", 32'(got.fault), 32'(want.fault));
		endtask
	endclass

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	v2m_pkg::req_t  req_data;
	logic           res_valid;
	logic           res_ready;
	v2m_pkg::res_t  res_data;

	vector_scoreboard board;
	bit    steady;   // no idling on either side while set

	vector2d_math_unit_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// receiver stalls at random, driven on the falling edge
	always @(negedge clk) begin
		res_ready <= steady ? 1'b1 : ($urandom_range(99) >= 16);
	end

	// every result is checked against the oldest outstanding request
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) board.check_result(res_data);
	end

	// one request: random gaps first, then hold valid until it is taken
	task send(v2m_pkg::req_t r);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 16) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_data = r;
		do @(posedge clk); while (!req_ready);
		board.note_request(r);
	endtask

	// a coordinate: extremes, zero and near zero, small values, or anything
	function logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'(int'($urandom_range(2)) - 1);
			3, 4: return 32'(int'($urandom_range(2 ** 21)) - 2 ** 20);
			5: return 32'(int'($urandom_range(2 ** 27)) - 2 ** 26);
			default: return $urandom;
		endcase
	endfunction

	function v2m_pkg::req_t random_request();
		v2m_pkg::req_t r;
		r.op = v2m_pkg::op_t'($urandom_range(7));
		r.first_x = pick_value();
		r.first_y = pick_value();
		r.second_x = pick_value();
		r.second_y = pick_value();
		r.angle = $urandom;
		r.weight = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(65536));
		// force the zero vector, equal vector and quarter-turn angle cases now and then
		case ($urandom_range(11))
			0: begin r.first_x = 0; r.first_y = 0; end
			1: begin r.second_x = 0; r.second_y = 0; end
			2: begin r.second_x = r.first_x; r.second_y = r.first_y; end
			3: r.angle = {2'($urandom_range(3)), 30'd0};
			default: ;
		endcase
		return r;
	endfunction

	function v2m_pkg::req_t make(v2m_pkg::op_t op, int ax, int ay, int bx, int by,
			int ang, int w);
		v2m_pkg::req_t r;
		r.op = op; r.first_x = ax; r.first_y = ay; r.second_x = bx; r.second_y = by;
		r.angle = ang; r.weight = w;
		return r;
	endfunction

	localparam int MAXP = 32'sh7fff_ffff;
	localparam int MAXN = 32'sh8000_0000;

	initial begin
		int waited;
		board = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		res_ready = 1'b0;
		steady = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: each operation, field extremes and the special cases
		send(make(v2m_pkg::OP_ROTATE, 65536, 0, 0, 0, 32'h4000_0000, 0));
		send(make(v2m_pkg::OP_ROTATE, MAXP, MAXN, 0, 0, MAXN, 0));
		send(make(v2m_pkg::OP_ROTATE, MAXN, MAXN, 0, 0, 32'h2000_0000, 0));
		send(make(v2m_pkg::OP_POLAR, MAXP, -1, -1, -1, -1, -1));
		send(make(v2m_pkg::OP_POLAR, MAXN, 0, 0, 0, 32'shc000_0000, 0));
		send(make(v2m_pkg::OP_MAG_ANGLE, 0, 0, 0, 0, 0, 0));
		send(make(v2m_pkg::OP_MAG_ANGLE, MAXN, MAXN, 0, 0, 0, 0));
		send(make(v2m_pkg::OP_MAG_ANGLE, -65536, 0, 0, 0, 0, 0));
		send(make(v2m_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0, 0));
		send(make(v2m_pkg::OP_NORMALIZE, 1, 0, 0, 0, 0, 0));
		send(make(v2m_pkg::OP_NORMALIZE, MAXP, MAXN, 0, 0, 0, 0));
		send(make(v2m_pkg::OP_DOT, MAXN, MAXN, MAXN, MAXN, 0, 0));
		send(make(v2m_pkg::OP_DOT, MAXP, MAXN, MAXN, MAXP, 0, 0));
		send(make(v2m_pkg::OP_DISTANCE, 5, 5, 5, 5, 0, 0));
		send(make(v2m_pkg::OP_DISTANCE, MAXN, MAXN, MAXP, MAXP, 0, 0));
		send(make(v2m_pkg::OP_LERP, MAXN, MAXP, MAXP, MAXN, 0, MAXN));
		send(make(v2m_pkg::OP_LERP, MAXN, MAXP, MAXP, MAXN, 0, MAXP));
		send(make(v2m_pkg::OP_LERP, 0, 65536, 65536, 0, 0, 32768));
		send(make(v2m_pkg::OP_ANGLE_BETWEEN, 0, 0, 1, 1, 0, 0));
		send(make(v2m_pkg::OP_ANGLE_BETWEEN, 1, 1, 0, 0, 0, 0));
		send(make(v2m_pkg::OP_ANGLE_BETWEEN, 65536, 0, -65536, 0, 0, 0));
		send(make(v2m_pkg::OP_ANGLE_BETWEEN, 0, 65536, 0, -65536, 0, 0));
		send(make(v2m_pkg::OP_ANGLE_BETWEEN, MAXP, MAXN, MAXN, MAXP, 0, 0));

		// random part, with a stretch without stalls or gaps in the middle
		for (int n = 0; n < 750; n++) begin
			steady = (n >= 300 && n < 420);
			send(random_request());
		end
		steady = 1'b0;
		@(negedge clk);
		req_valid = 1'b0;

		waited = 0;
		while (board.pending.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (board.pending.size() != 0)
			board.report($sformatf("%0d results never arrived", board.pending.size()));
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#4ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
